@@ src/dmc_pkg.sv @@
// shared constants and helpers for the direct-mapped write-back cache tag controller
// no dependencies; compiled first
package dmc_pkg;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned OFFSET_W   = 5;
	localparam int unsigned BLOCK_W    = 27;
	localparam int unsigned INDEX_W    = 7;
	localparam int unsigned TAG_W      = 20;
	localparam int unsigned CNT_W      = 32;

	localparam int unsigned DEF_NUM_LINES   = 128;
	localparam int unsigned DEF_BLOCK_BYTES = 32;

	// floor of log2, used at elaboration only
	function automatic int unsigned flog2(input int unsigned v);
		int unsigned n;
		int unsigned x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			n = n + 1;
		end
		return n;
	endfunction

endpackage

@@ src/dmc_if.sv @@
// request and response channel interfaces of the cache tag controller
// depends on dmc_pkg
interface dmc_req_if;
	import dmc_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;
	logic              is_write;

	modport source (output valid, output address, output is_write, input ready);
	modport sink   (input valid, input address, input is_write, output ready);
endinterface

interface dmc_rsp_if;
	import dmc_pkg::*;

	logic                valid;
	logic                ready;
	logic [OFFSET_W-1:0] byte_offset;
	logic [BLOCK_W-1:0]  block_number;
	logic [INDEX_W-1:0]  line_index;
	logic [TAG_W-1:0]    tag_value;
	logic                miss;
	logic                mem_read;
	logic                mem_write;
	logic                replaced;
	logic [TAG_W-1:0]    evicted_tag;
	logic [CNT_W-1:0]    hit_total;
	logic [CNT_W-1:0]    miss_total;
	logic [CNT_W-1:0]    writeback_total;

	modport source (output valid, output byte_offset, output block_number, output line_index,
		output tag_value, output miss, output mem_read, output mem_write, output replaced,
		output evicted_tag, output hit_total, output miss_total, output writeback_total,
		input ready);
	modport sink (input valid, input byte_offset, input block_number, input line_index,
		input tag_value, input miss, input mem_read, input mem_write, input replaced,
		input evicted_tag, input hit_total, input miss_total, input writeback_total,
		output ready);
endinterface

@@ src/dmc_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module dmc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/dmc_lookup.sv @@
// lookup stage: tag compare, line update, counters and result register
// depends on dmc_pkg, dmc_if; line state is read from and written to an external ram
module dmc_lookup #(
	parameter int unsigned NUM_LINES   = dmc_pkg::DEF_NUM_LINES,
	parameter int unsigned BLOCK_BYTES = dmc_pkg::DEF_BLOCK_BYTES,
	localparam int unsigned OFF_BITS = dmc_pkg::flog2(BLOCK_BYTES),
	localparam int unsigned IDX_BITS = dmc_pkg::flog2(NUM_LINES),
	localparam int unsigned TAGB     = dmc_pkg::ADDR_W - OFF_BITS - IDX_BITS,
	localparam int unsigned ENT_W    = TAGB + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	dmc_req_if.sink             req,
	dmc_rsp_if.source           rsp,
	input  logic                busy,
	output logic                rd_en,
	output logic [IDX_BITS-1:0] rd_idx,
	input  logic [ENT_W-1:0]    rd_data,
	output logic                wr_en,
	output logic [IDX_BITS-1:0] wr_idx,
	output logic [ENT_W-1:0]    wr_data
);
	import dmc_pkg::*;

	localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << OFF_BITS) - 64'd1);
	localparam logic [ADDR_W-1:0] IDX_MASK = ADDR_W'((64'd1 << IDX_BITS) - 64'd1);
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	// stage 1
	logic              vld_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              wr_s1;

	// last line written, forwarded over the ram's read-during-write
	logic                fwd_vld_q;
	logic [IDX_BITS-1:0] fwd_idx_q;
	logic [ENT_W-1:0]    fwd_data_q;

	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, wb_cnt_q;
	logic             out_vld_q;

	logic                acc, adv;
	logic [IDX_BITS-1:0] idx1;
	logic [TAGB-1:0]     tag1;
	logic [ENT_W-1:0]    ent;
	logic                ent_v, ent_d, hit, wb;
	logic [TAGB-1:0]     ent_tag;
	logic [ADDR_W-1:0]   off_w, blk_w, lidx_w, tag_w, evict_w;
	logic [CNT_W-1:0]    hit_nx, miss_nx, wb_nx;

	assign adv       = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !busy && (!vld_s1 || adv);
	assign acc       = req.valid && req.ready;

	assign rd_en  = acc;
	assign rd_idx = req.address[OFF_BITS +: IDX_BITS];

	assign idx1 = addr_s1[OFF_BITS +: IDX_BITS];
	assign tag1 = addr_s1[ADDR_W-1 -: TAGB];

	always_comb begin
		ent = (fwd_vld_q && fwd_idx_q == idx1) ? fwd_data_q : rd_data;
	end

	assign ent_v   = ent[ENT_W-1];
	assign ent_d   = ent[ENT_W-2];
	assign ent_tag = ent[TAGB-1:0];
	assign hit     = ent_v && (ent_tag == tag1);
	assign wb      = !hit && ent_v && ent_d;

	// line always rewritten: hit keeps dirty and a write sets it, miss installs the new tag
	assign wr_en   = adv;
	assign wr_idx  = idx1;
	assign wr_data = {1'b1, hit ? (ent_d | wr_s1) : wr_s1, tag1};

	assign hit_nx  = (hit && hit_cnt_q != CNT_MAX) ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;
	assign miss_nx = (!hit && miss_cnt_q != CNT_MAX) ? miss_cnt_q + CNT_W'(1) : miss_cnt_q;
	assign wb_nx   = (wb && wb_cnt_q != CNT_MAX) ? wb_cnt_q + CNT_W'(1) : wb_cnt_q;

	assign off_w   = addr_s1 & OFF_MASK;
	assign blk_w   = addr_s1 >> OFF_BITS;
	assign lidx_w  = blk_w & IDX_MASK;
	assign tag_w   = addr_s1 >> (OFF_BITS + IDX_BITS);
	assign evict_w = (!hit && ent_v) ? ADDR_W'(ent_tag) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			fwd_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			wb_cnt_q   <= '0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				fwd_vld_q  <= 1'b1;
				out_vld_q  <= 1'b1;
				hit_cnt_q  <= hit_nx;
				miss_cnt_q <= miss_nx;
				wb_cnt_q   <= wb_nx;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1 <= req.address;
			wr_s1   <= req.is_write;
		end
		if (adv) begin
			fwd_idx_q            <= idx1;
			fwd_data_q           <= wr_data;
			rsp.byte_offset      <= off_w[OFFSET_W-1:0];
			rsp.block_number     <= blk_w[BLOCK_W-1:0];
			rsp.line_index       <= lidx_w[INDEX_W-1:0];
			rsp.tag_value        <= tag_w[TAG_W-1:0];
			rsp.miss             <= !hit;
			rsp.mem_read         <= !hit;
			rsp.mem_write        <= wb;
			rsp.replaced         <= !hit && ent_v;
			rsp.evicted_tag      <= evict_w[TAG_W-1:0];
			rsp.hit_total        <= hit_nx;
			rsp.miss_total       <= miss_nx;
			rsp.writeback_total  <= wb_nx;
		end
	end

	assign rsp.valid = out_vld_q;

endmodule

@@ src/direct_mapped_writeback_cache_tags.sv @@
// top level of the direct-mapped write-back write-allocate cache tag controller
// depends on dmc_pkg, dmc_if, dmc_ram, dmc_lookup
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+------------------------------------------------
//  req     | in  | valid / ready   | address, is_write
//  rsp     | out | valid / ready   | offset, block, line, tag, miss/fill/writeback
//          |     |                 | flags, evicted tag, hit/miss/writeback totals
//
// one access per cycle sustained while rsp.ready is high and no clearing pass runs
// (ram read at transfer; line compare, write back and result load as stage 1 advances)
// back-to-back accesses to the same line see the previous update through a
// forwarding register in front of the ram's registered read port
// after reset a clearing pass writes every line entry invalid, one per cycle,
// all 2**floor(log2(NUM_LINES)) of them (128 by default), with req.ready low
// a stalled result register holds stage 1, which in turn holds req.ready low
module direct_mapped_writeback_cache_tags #(
	parameter int unsigned NUM_LINES   = dmc_pkg::DEF_NUM_LINES,
	parameter int unsigned BLOCK_BYTES = dmc_pkg::DEF_BLOCK_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	dmc_req_if.sink   req,
	dmc_rsp_if.source rsp
);
	import dmc_pkg::*;

	localparam int unsigned OFF_BITS = flog2(BLOCK_BYTES);
	localparam int unsigned IDX_BITS = flog2(NUM_LINES);
	localparam int unsigned DEPTH    = 1 << IDX_BITS;
	// ram entry: valid, dirty, stored tag
	localparam int unsigned ENT_W    = ADDR_W - OFF_BITS - IDX_BITS + 2;

	// clearing pass state
	logic                clearing_q;
	logic [IDX_BITS-1:0] clr_idx_q;

	// lookup side of the ram
	logic                lk_rd_en;
	logic [IDX_BITS-1:0] lk_rd_idx;
	logic [ENT_W-1:0]    ram_rdata;
	logic                lk_wr_en;
	logic [IDX_BITS-1:0] lk_wr_idx;
	logic [ENT_W-1:0]    lk_wr_data;

	// ram write port, owned by the clearing pass until it finishes
	logic                ram_we;
	logic [IDX_BITS-1:0] ram_waddr;
	logic [ENT_W-1:0]    ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == IDX_BITS'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + IDX_BITS'(1);
			end
		end
	end

	assign ram_we    = clearing_q || lk_wr_en;
	assign ram_waddr = clearing_q ? clr_idx_q : lk_wr_idx;
	assign ram_wdata = clearing_q ? '0 : lk_wr_data;

	dmc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (lk_rd_en),
		.raddr (lk_rd_idx),
		.rdata (ram_rdata)
	);

	dmc_lookup #(
		.NUM_LINES   (NUM_LINES),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_lookup (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.busy    (clearing_q),
		.rd_en   (lk_rd_en),
		.rd_idx  (lk_rd_idx),
		.rd_data (ram_rdata),
		.wr_en   (lk_wr_en),
		.wr_idx  (lk_wr_idx),
		.wr_data (lk_wr_data)
	);

endmodule
